/* src/gbfs_pkg.sv */
// Package for the graph search engine: field widths, request codes and the
// command/status words shared by the controller and the datapath.
// No dependencies.
package gbfs_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VERTEX_W         = 7;
  localparam int DIST_W           = 6;
  localparam int CNT_W            = 16;
  localparam int CFG_W            = 7;
  localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    REQ_EDGE   = 2'd0,
    REQ_ARC    = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_SEARCH = 2'd3
  } req_e;

  typedef struct packed {
    logic cap;
    logic rd_a;
    logic wr_a;
    logic rd_b;
    logic wr_b;
    logic bump;
    logic clr;
    logic init;
    logic deq;
    logic rd_u;
    logic load;
    logic scan;
    logic dump_start;
    logic dump_rd;
    logic dump_next;
    logic out_ack;
    logic out_dump;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic add_ok;
    logic src_ok;
    logic q_more;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

/* src/gbfs_ctrl.sv */
// Controller of the graph search engine: one-hot sequencer issuing commands.
// Depends on gbfs_pkg.
module gbfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  gbfs_pkg::stat_t  stat_i,
  output gbfs_pkg::cmd_t   cmd_o
);
  import gbfs_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_DEC  = 14'b00000000000010,
    S_RDA  = 14'b00000000000100,
    S_WRA  = 14'b00000000001000,
    S_RDB  = 14'b00000000010000,
    S_WRB  = 14'b00000000100000,
    S_ACK  = 14'b00000001000000,
    S_INIT = 14'b00000010000000,
    S_DEQ  = 14'b00000100000000,
    S_DQW  = 14'b00001000000000,
    S_LOAD = 14'b00010000000000,
    S_SCAN = 14'b00100000000000,
    S_DRD  = 14'b01000000000000,
    S_DOUT = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DEC;
        end
      end
      S_DEC: begin
        case (stat_i.req)
          REQ_EDGE, REQ_ARC: state_d = stat_i.add_ok ? S_RDA : S_ACK;
          REQ_CLEAR: begin
            cmd_o.clr = 1'b1;
            state_d   = S_ACK;
          end
          REQ_SEARCH: state_d = stat_i.src_ok ? S_INIT : S_ACK;
          default: state_d = S_ACK;
        endcase
      end
      S_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d    = S_WRA;
      end
      S_WRA: begin
        cmd_o.wr_a = 1'b1;
        if (stat_i.req == REQ_ARC) begin
          cmd_o.bump = 1'b1;
          state_d    = S_ACK;
        end else begin
          state_d = S_RDB;
        end
      end
      S_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_WRB;
      end
      S_WRB: begin
        cmd_o.wr_b = 1'b1;
        cmd_o.bump = 1'b1;
        state_d    = S_ACK;
      end
      S_ACK: begin
        if (stat_i.out_free) begin
          cmd_o.out_ack = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_DEQ;
      end
      S_DEQ: begin
        if (stat_i.q_more) begin
          cmd_o.deq = 1'b1;
          state_d   = S_DQW;
        end else begin
          cmd_o.dump_start = 1'b1;
          state_d          = S_DRD;
        end
      end
      S_DQW: begin
        cmd_o.rd_u = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DEQ;
        end
      end
      S_DRD: begin
        cmd_o.dump_rd = 1'b1;
        state_d       = S_DOUT;
      end
      S_DOUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_dump = 1'b1;
          if (stat_i.scan_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.dump_next = 1'b1;
            state_d         = S_DRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/gbfs_dpath.sv */
// Datapath of the graph search engine: adjacency, queue and result memories,
// counters and the output register. Depends on gbfs_pkg.
module gbfs_dpath #(
  parameter int MaxVertices = gbfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [gbfs_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [1:0]                    req_type_i,
  input  logic [gbfs_pkg::VERTEX_W-1:0] first_vertex_i,
  input  logic [gbfs_pkg::VERTEX_W-1:0] second_vertex_i,
  input  gbfs_pkg::cmd_t                cmd_i,
  output gbfs_pkg::stat_t               stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbfs_pkg::VERTEX_W-1:0] vertex_o,
  output logic [gbfs_pkg::DIST_W-1:0]   distance_o,
  output logic [gbfs_pkg::VERTEX_W-1:0] parent_o,
  output logic                          reached_o,
  output logic [gbfs_pkg::CNT_W-1:0]    edge_total_o,
  output logic                          error_o,
  output logic                          last_o
);
  import gbfs_pkg::*;

  localparam int NV = (MaxVertices < 64) ? MaxVertices : 64;
  localparam int IW = (NV > 1) ? $clog2(NV) : 1;
  localparam int CW = $clog2(NV + 1);
  localparam int QW = VERTEX_W + DIST_W;

  logic [CFG_W-1:0]    vcount_q;
  req_e                req_q;
  logic [VERTEX_W-1:0] a_q, b_q;
  logic [CW-1:0]       n_q, n_clamp, n_m1;

  logic [NV-1:0]       adj_mem [NV];
  logic [NV-1:0]       row_valid_q;
  logic [NV-1:0]       adj_rd_q;
  logic                adj_rv_q;
  logic [NV-1:0]       row_data;
  logic [IW-1:0]       adj_raddr, adj_waddr;
  logic [NV-1:0]       adj_wdata;

  logic [QW-1:0]       q_mem [NV];
  logic [QW-1:0]       q_rd_q;
  logic [QW-1:0]       q_wdata;
  logic [IW-1:0]       q_waddr;
  logic                q_we;
  logic [CW-1:0]       head_q, tail_q;

  logic [QW-1:0]       dp_mem [NV];
  logic [QW-1:0]       dp_rd_q;
  logic [QW-1:0]       dp_wdata;
  logic [IW-1:0]       dp_waddr;
  logic                dp_we;

  logic [NV-1:0]       vis_q;
  logic [NV-1:0]       row_q;
  logic [CW-1:0]       i_q;
  logic [IW-1:0]       i_idx;
  logic [VERTEX_W-1:0] u_q;
  logic [DIST_W-1:0]   ud_q, ud_inc;
  logic [CNT_W-1:0]    cnt_q;

  logic [VERTEX_W-1:0] a_m1, b_m1, qu_m1, n_ext, i_vtx;
  logic                a_ok, b_ok, enq, err;

  always_comb begin
    if (vcount_q == '0) begin
      n_clamp = CW'(1);
    end else if (32'(vcount_q) > 32'(NV)) begin
      n_clamp = CW'(NV);
    end else begin
      n_clamp = vcount_q[CW-1:0];
    end
  end

  assign n_m1   = n_q - CW'(1);
  assign n_ext  = VERTEX_W'(n_q);
  assign a_m1   = a_q - VERTEX_W'(1);
  assign b_m1   = b_q - VERTEX_W'(1);
  assign qu_m1  = q_rd_q[QW-1:DIST_W] - VERTEX_W'(1);
  assign a_ok   = (a_q != '0) && (a_q <= n_ext);
  assign b_ok   = (b_q != '0) && (b_q <= n_ext);
  assign i_idx  = i_q[IW-1:0];
  assign i_vtx  = VERTEX_W'(i_q) + VERTEX_W'(1);
  assign ud_inc = ud_q + DIST_W'(1);
  assign enq    = row_q[0] && !vis_q[i_idx] && (tail_q < n_q);

  always_comb begin
    case (req_q)
      REQ_EDGE, REQ_ARC: err = !(a_ok && b_ok);
      REQ_SEARCH:        err = !a_ok;
      default:           err = 1'b0;
    endcase
  end

  assign stat_o.req       = req_q;
  assign stat_o.add_ok    = a_ok && b_ok;
  assign stat_o.src_ok    = a_ok;
  assign stat_o.q_more    = (head_q < tail_q) && (head_q < n_q);
  assign stat_o.scan_last = (i_q == n_m1);
  assign stat_o.out_free  = !out_valid_o || !out_stall_i;

  // adjacency store
  assign row_data  = adj_rv_q ? adj_rd_q : '0;
  assign adj_raddr = cmd_i.rd_u ? qu_m1[IW-1:0] : (cmd_i.rd_b ? b_m1[IW-1:0] : a_m1[IW-1:0]);
  assign adj_waddr = cmd_i.wr_b ? b_m1[IW-1:0] : a_m1[IW-1:0];
  assign adj_wdata = row_data | (NV'(1) << (cmd_i.wr_b ? a_m1[IW-1:0] : b_m1[IW-1:0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a || cmd_i.wr_b) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (cmd_i.rd_a || cmd_i.rd_b || cmd_i.rd_u) begin
      adj_rd_q <= adj_mem[adj_raddr];
      adj_rv_q <= row_valid_q[adj_raddr];
    end
  end

  // queue and result stores
  assign q_we     = cmd_i.init || (cmd_i.scan && enq);
  assign q_waddr  = cmd_i.init ? IW'(0) : tail_q[IW-1:0];
  assign q_wdata  = cmd_i.init ? {a_q, DIST_W'(0)} : {i_vtx, ud_inc};
  assign dp_we    = q_we;
  assign dp_waddr = cmd_i.init ? a_m1[IW-1:0] : i_idx;
  assign dp_wdata = cmd_i.init ? '0 : {ud_inc, u_q};

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (cmd_i.deq) begin
      q_rd_q <= q_mem[head_q[IW-1:0]];
    end
    if (dp_we) begin
      dp_mem[dp_waddr] <= dp_wdata;
    end
    if (cmd_i.dump_rd) begin
      dp_rd_q <= dp_mem[i_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      a_q <= first_vertex_i;
      b_q <= second_vertex_i;
      n_q <= n_clamp;
    end
    if (cmd_i.rd_u) begin
      u_q  <= q_rd_q[QW-1:DIST_W];
      ud_q <= q_rd_q[DIST_W-1:0];
    end
    if (cmd_i.load) begin
      row_q <= row_data;
    end else if (cmd_i.scan) begin
      row_q <= row_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= VCOUNT_RESET;
      req_q       <= REQ_EDGE;
      row_valid_q <= '0;
      cnt_q       <= '0;
      vis_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      i_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        vcount_q <= cfg_data_i;
      end
      if (cmd_i.cap) begin
        req_q <= req_e'(req_type_i);
      end
      if (cmd_i.clr) begin
        row_valid_q <= '0;
        cnt_q       <= '0;
      end else begin
        if (cmd_i.wr_a || cmd_i.wr_b) begin
          row_valid_q[adj_waddr] <= 1'b1;
        end
        if (cmd_i.bump && (cnt_q != '1)) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.init) begin
        vis_q  <= NV'(1) << a_m1[IW-1:0];
        head_q <= '0;
        tail_q <= CW'(1);
      end
      if (cmd_i.deq) begin
        head_q <= head_q + CW'(1);
      end
      if (cmd_i.scan && enq) begin
        vis_q[i_idx] <= 1'b1;
        tail_q       <= tail_q + CW'(1);
      end
      if (cmd_i.load || cmd_i.dump_start) begin
        i_q <= '0;
      end else if (cmd_i.scan || cmd_i.dump_next) begin
        i_q <= i_q + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_ack || cmd_i.out_dump) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ack) begin
      vertex_o     <= '0;
      distance_o   <= '0;
      parent_o     <= '0;
      reached_o    <= 1'b0;
      edge_total_o <= cnt_q;
      error_o      <= err;
      last_o       <= 1'b1;
    end else if (cmd_i.out_dump) begin
      vertex_o     <= i_vtx;
      distance_o   <= vis_q[i_idx] ? dp_rd_q[QW-1:VERTEX_W] : '0;
      parent_o     <= vis_q[i_idx] ? dp_rd_q[VERTEX_W-1:0] : '0;
      reached_o    <= vis_q[i_idx];
      edge_total_o <= cnt_q;
      error_o      <= 1'b0;
      last_o       <= (i_q == n_m1);
    end
  end

endmodule

/* src/graph_bfs_engine_top.sv */
// Top level of the graph search engine: controller plus datapath.
// Depends on gbfs_pkg, gbfs_ctrl and gbfs_dpath.
//
//   channel  handshake              word
//   in       in_valid_i/in_stall_o  req_type, first_vertex, second_vertex
//   out      out_valid_o/out_stall_i vertex, distance, parent, reached,
//                                   edge_total, error, last
//   cfg      cfg_valid_i/cfg_ready_o vertex_count
//
// Clear and rejected requests go straight to the result; arcs first write one
// adjacency row, edges two. A search walks the adjacency row of each reached
// vertex one bit per cycle, then emits one result word per vertex.
// Reset (rst_ni, asynchronous) empties the graph and the edge count.
// Out stalls hold the engine once a further word is ready.
module graph_bfs_engine_top #(
  parameter int MAX_VERTICES = gbfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gbfs_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [gbfs_pkg::VERTEX_W-1:0] first_vertex_i,
  input  logic [gbfs_pkg::VERTEX_W-1:0] second_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbfs_pkg::VERTEX_W-1:0] vertex_o,
  output logic [gbfs_pkg::DIST_W-1:0]   distance_o,
  output logic [gbfs_pkg::VERTEX_W-1:0] parent_o,
  output logic                          reached_o,
  output logic [gbfs_pkg::CNT_W-1:0]    edge_total_o,
  output logic                          error_o,
  output logic                          last_o
);
  import gbfs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  gbfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gbfs_dpath #(
    .MaxVertices (MAX_VERTICES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vertex_o        (vertex_o),
    .distance_o      (distance_o),
    .parent_o        (parent_o),
    .reached_o       (reached_o),
    .edge_total_o    (edge_total_o),
    .error_o         (error_o),
    .last_o          (last_o)
  );

endmodule

/* dv/graph_bfs_engine_top_tb.sv */
// Testbench for graph_bfs_engine_top: drives edge, arc, clear and search words,
// predicts every result word from a local graph model and checks them in order.
// Depends on gbfs_pkg and the RTL of graph_bfs_engine_top.
`timescale 1ns / 1ps

module graph_bfs_engine_top_tb;
  import gbfs_pkg::*;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [DIST_W-1:0]   distance;
    logic [VERTEX_W-1:0] parent;
    logic                reached;
    logic [CNT_W-1:0]    edge_total;
    logic                error;
    logic                last;
  } bfs_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [VERTEX_W-1:0] first_vertex_i = '0;
  logic [VERTEX_W-1:0] second_vertex_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [VERTEX_W-1:0] vertex_o;
  logic [DIST_W-1:0] distance_o;
  logic [VERTEX_W-1:0] parent_o;
  logic reached_o;
  logic [CNT_W-1:0] edge_total_o;
  logic error_o;
  logic last_o;

  graph_bfs_engine_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [63:0] graph_rows [64];
  int unsigned edge_count;
  int unsigned vcount_reg;
  bfs_word_t expected_words [$];
  int unsigned fail_count;
  int unsigned word_count;
  int unsigned search_count;
  int unsigned hold_cycles;
  bit stall_random;

  function automatic int unsigned live_count();
    int unsigned n;
    n = vcount_reg;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  function automatic bfs_word_t ack_word(logic err);
    bfs_word_t w;
    w = '0;
    w.edge_total = edge_count[CNT_W-1:0];
    w.error = err;
    w.last = 1'b1;
    return w;
  endfunction

  task automatic predict_request(req_e req, int unsigned a, int unsigned b);
    int unsigned n, head, tail, u;
    logic [63:0] mask, row;
    int unsigned hop_dist [64];
    int unsigned par [64];
    bit seen [64];
    int unsigned queue_v [64];
    bfs_word_t w;
    n = live_count();
    mask = (n >= 64) ? '1 : ((64'd1 << n) - 1);
    if (req == REQ_EDGE || req == REQ_ARC) begin
      if (a < 1 || a > n || b < 1 || b > n) begin
        expected_words.push_back(ack_word(1'b1));
        return;
      end
      graph_rows[a-1][b-1] = 1'b1;
      if (req == REQ_EDGE) graph_rows[b-1][a-1] = 1'b1;
      if (edge_count < 16'hFFFF) edge_count++;
      expected_words.push_back(ack_word(1'b0));
      return;
    end
    if (req == REQ_CLEAR) begin
      foreach (graph_rows[i]) graph_rows[i] = '0;
      edge_count = 0;
      expected_words.push_back(ack_word(1'b0));
      return;
    end
    if (a < 1 || a > n) begin
      expected_words.push_back(ack_word(1'b1));
      return;
    end
    for (int i = 0; i < 64; i++) begin
      hop_dist[i] = 0;
      par[i] = 0;
      seen[i] = 0;
    end
    seen[a-1] = 1;
    head = 0;
    tail = 0;
    queue_v[tail++] = a;
    while (head < tail && head < n) begin
      u = queue_v[head++];
      row = graph_rows[u-1] & mask;
      for (int i = 0; i < n; i++) begin
        if (row[i] && !seen[i] && tail < n) begin
          seen[i] = 1;
          hop_dist[i] = (hop_dist[u-1] + 1) & 6'h3F;
          par[i] = u;
          queue_v[tail++] = i + 1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      w = '0;
      w.vertex = VERTEX_W'(i + 1);
      w.distance = DIST_W'(hop_dist[i]);
      w.parent = VERTEX_W'(par[i]);
      w.reached = seen[i];
      w.edge_total = edge_count[CNT_W-1:0];
      w.last = (i + 1 == n);
      expected_words.push_back(w);
    end
    search_count++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(req_e req, int unsigned a, int unsigned b);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_request(req, a, b);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    first_vertex_i <= VERTEX_W'(a);
    second_vertex_i <= VERTEX_W'(b);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_vcount(int unsigned value);
    drain_words();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    vcount_reg = value & 7'h7F;
  endtask

  // check each accepted result word against the oldest prediction
  always @(posedge clk_i) begin
    bfs_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      word_count++;
      if (expected_words.size() == 0) begin
        $error("unexpected result word vertex=%0d", vertex_o);
        fail_count++;
      end else begin
        w = expected_words.pop_front();
        if (vertex_o !== w.vertex) begin
          $error("vertex exp %0d got %0d", w.vertex, vertex_o); fail_count++;
        end
        if (distance_o !== w.distance) begin
          $error("distance exp %0d got %0d", w.distance, distance_o); fail_count++;
        end
        if (parent_o !== w.parent) begin
          $error("parent exp %0d got %0d", w.parent, parent_o); fail_count++;
        end
        if (reached_o !== w.reached) begin
          $error("reached exp %0d got %0d", w.reached, reached_o); fail_count++;
        end
        if (edge_total_o !== w.edge_total) begin
          $error("edge_total exp %0d got %0d", w.edge_total, edge_total_o); fail_count++;
        end
        if (error_o !== w.error) begin
          $error("error exp %0d got %0d", w.error, error_o); fail_count++;
        end
        if (last_o !== w.last) begin
          $error("last exp %0d got %0d", w.last, last_o); fail_count++;
        end
      end
    end
  end

  // receiver stall: random, always ready, or a long counted hold-off
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (!stall_random) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 25);
    end
  end

  task automatic test_directed_edges();
    write_vcount(64);
    send_word(REQ_EDGE, 1, 64);
    send_word(REQ_ARC, 64, 2);
    send_word(REQ_EDGE, 0, 5);
    send_word(REQ_ARC, 5, 65);
    send_word(REQ_EDGE, 127, 127);
    send_word(REQ_EDGE, 3, 3);
    send_word(REQ_EDGE, 1, 64);
    send_word(REQ_ARC, 2, 3);
    send_word(REQ_SEARCH, 1, 0);
    send_word(REQ_SEARCH, 0, 9);
    send_word(REQ_SEARCH, 65, 0);
    send_word(REQ_SEARCH, 3, 127);
  endtask

  task automatic test_small_counts();
    write_vcount(0);
    send_word(REQ_SEARCH, 1, 0);
    send_word(REQ_EDGE, 1, 2);
    write_vcount(127);
    send_word(REQ_SEARCH, 64, 0);
    write_vcount(4);
    send_word(REQ_SEARCH, 1, 0);
    send_word(REQ_SEARCH, 5, 0);
    send_word(REQ_CLEAR, 77, 42);
    send_word(REQ_SEARCH, 2, 0);
  endtask

  task automatic test_random_graphs();
    int unsigned n, r, a, b;
    int unsigned counts [5] = '{3, 8, 16, 5, 64};
    foreach (counts[k]) begin
      write_vcount(counts[k]);
      n = counts[k];
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(0, 99);
        a = (r % 13 == 0) ? $urandom_range(0, 127) : $urandom_range(1, n);
        b = (r % 11 == 0) ? $urandom_range(0, 127) : $urandom_range(1, n);
        if (r < 2) send_word(REQ_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127));
        else if (r < 50) send_word(REQ_EDGE, a, b);
        else if (r < 80) send_word(REQ_ARC, a, b);
        else send_word(REQ_SEARCH, a, $urandom_range(0, 127));
      end
    end
  endtask

  task automatic test_backpressure();
    write_vcount(8);
    hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      send_word(i % 4 == 3 ? REQ_SEARCH : REQ_EDGE, $urandom_range(1, 8), $urandom_range(1, 8));
    drain_words();
    stall_random = 0;
    for (int i = 0; i < 10; i++) send_word(REQ_ARC, $urandom_range(1, 8), $urandom_range(1, 8));
    send_word(REQ_SEARCH, 1, 0);
    stall_random = 1;
  endtask

  initial begin
    hold_cycles = 0;
    stall_random = 1;
    fail_count = 0;
    word_count = 0;
    search_count = 0;
    edge_count = 0;
    vcount_reg = VCOUNT_RESET;
    foreach (graph_rows[i]) graph_rows[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_small_counts();
    test_random_graphs();
    test_backpressure();
    drain_words();
    $display("Checked %0d result words across %0d searches and vertex counts 0 to 127.",
             word_count, search_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

endmodule
